>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the region allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, codes and sizes shared by the region allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 4;
    localparam int TAG_BITS   = 16;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int TAG_W      = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOT_COUNT - 1);

    // Request kinds.
    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;

    // Region kinds.
    localparam logic [1:0] KIND_EXTENDED = 2'd1;

    // Placement policies.
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EXT_EXISTS = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_NO_SPACE   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_RANGE      = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DISK_SIZE   = 2'd0;
    localparam logic [1:0] CFG_FIT_MODE    = 2'd1;
    localparam logic [1:0] CFG_HEADER_SIZE = 2'd2;
    localparam logic [15:0] HEADER_RESET   = 16'd152;

    // Microcode field widths.
    localparam int OP_W   = 4;
    localparam int COND_W = 4;
    localparam int PC_W   = 5;

    // Datapath operations.
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] OP_CR_INIT   = 4'd2;
    localparam logic [OP_W-1:0] OP_SCAN_CLR  = 4'd3;
    localparam logic [OP_W-1:0] OP_SCAN_STEP = 4'd4;
    localparam logic [OP_W-1:0] OP_GAP_FIT   = 4'd5;
    localparam logic [OP_W-1:0] OP_ADVANCE   = 4'd6;
    localparam logic [OP_W-1:0] OP_CR_COMMIT = 4'd7;
    localparam logic [OP_W-1:0] OP_DEL_STEP  = 4'd8;
    localparam logic [OP_W-1:0] OP_DEL_FIN   = 4'd9;
    localparam logic [OP_W-1:0] OP_RS_INIT   = 4'd10;
    localparam logic [OP_W-1:0] OP_RS_CALC   = 4'd11;
    localparam logic [OP_W-1:0] OP_RS_CHECK  = 4'd12;
    localparam logic [OP_W-1:0] OP_SET_NF    = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT      = 4'd14;

    // Jump conditions.
    localparam logic [COND_W-1:0] C_NEXT       = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
    localparam logic [COND_W-1:0] C_NO_START   = 4'd2;
    localparam logic [COND_W-1:0] C_IS_DELETE  = 4'd3;
    localparam logic [COND_W-1:0] C_IS_RESIZE  = 4'd4;
    localparam logic [COND_W-1:0] C_NOT_CREATE = 4'd5;
    localparam logic [COND_W-1:0] C_CR_ERR     = 4'd6;
    localparam logic [COND_W-1:0] C_SCAN_MORE  = 4'd7;
    localparam logic [COND_W-1:0] C_FIRST_HIT  = 4'd8;
    localparam logic [COND_W-1:0] C_CAND_SOME  = 4'd9;
    localparam logic [COND_W-1:0] C_CAND_NONE  = 4'd10;
    localparam logic [COND_W-1:0] C_TAG_MISS   = 4'd11;

    // Idle step of the program.
    localparam logic [PC_W-1:0] PC_IDLE = 5'd0;

    // One control word.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ucode_t;

    // Datapath conditions seen by the sequencer.
    typedef struct packed {
        logic is_create;
        logic is_delete;
        logic is_resize;
        logic cr_err;
        logic scan_more;
        logic first_hit;
        logic cand_some;
        logic tag_miss;
    } flags_t;

    // Result beat contents.
    typedef struct packed {
        logic [2:0]           status;
        logic [SLOT_BITS-1:0] slot;
        logic [31:0]          start;
        logic [31:0]          size;
    } res_t;

endpackage

`default_nettype wire

>>> hdl/pfa_ucode_rom.sv
// ----------------------------------------------------------------------------
// pfa_ucode_rom
// Read-only control store holding the allocator program.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ucode_rom
    import pfa_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output ucode_t          word
);

    // Program labels.
    localparam logic [PC_W-1:0] L_WAIT     = 5'd0;
    localparam logic [PC_W-1:0] L_CR_SCAN  = 5'd5;
    localparam logic [PC_W-1:0] L_CR_LOOP  = 5'd6;
    localparam logic [PC_W-1:0] L_CR_DONE  = 5'd9;
    localparam logic [PC_W-1:0] L_DEL      = 5'd10;
    localparam logic [PC_W-1:0] L_DEL_LOOP = 5'd11;
    localparam logic [PC_W-1:0] L_RSZ      = 5'd13;
    localparam logic [PC_W-1:0] L_RS_SCAN  = 5'd14;
    localparam logic [PC_W-1:0] L_RS_LOOP  = 5'd15;
    localparam logic [PC_W-1:0] L_RS_NLOOP = 5'd19;
    localparam logic [PC_W-1:0] L_NF       = 5'd22;
    localparam logic [PC_W-1:0] L_EMIT     = 5'd23;

    // The program: create walks the gaps in start order, delete scans for
    // the highest matching slot, resize finds the target and its successor.
    always_comb
    begin
        case (pc)
            5'd0:    word = '{OP_LOAD,      C_NO_START,   L_WAIT};
            5'd1:    word = '{OP_NOP,       C_IS_DELETE,  L_DEL};
            5'd2:    word = '{OP_NOP,       C_IS_RESIZE,  L_RSZ};
            5'd3:    word = '{OP_NOP,       C_NOT_CREATE, L_NF};
            5'd4:    word = '{OP_CR_INIT,   C_CR_ERR,     L_EMIT};
            5'd5:    word = '{OP_SCAN_CLR,  C_NEXT,       L_WAIT};
            5'd6:    word = '{OP_SCAN_STEP, C_SCAN_MORE,  L_CR_LOOP};
            5'd7:    word = '{OP_GAP_FIT,   C_FIRST_HIT,  L_CR_DONE};
            5'd8:    word = '{OP_ADVANCE,   C_CAND_SOME,  L_CR_SCAN};
            5'd9:    word = '{OP_CR_COMMIT, C_ALWAYS,     L_EMIT};
            5'd10:   word = '{OP_SCAN_CLR,  C_NEXT,       L_WAIT};
            5'd11:   word = '{OP_DEL_STEP,  C_SCAN_MORE,  L_DEL_LOOP};
            5'd12:   word = '{OP_DEL_FIN,   C_ALWAYS,     L_EMIT};
            5'd13:   word = '{OP_RS_INIT,   C_NEXT,       L_WAIT};
            5'd14:   word = '{OP_SCAN_CLR,  C_NEXT,       L_WAIT};
            5'd15:   word = '{OP_SCAN_STEP, C_SCAN_MORE,  L_RS_LOOP};
            5'd16:   word = '{OP_NOP,       C_CAND_NONE,  L_NF};
            5'd17:   word = '{OP_ADVANCE,   C_TAG_MISS,   L_RS_SCAN};
            5'd18:   word = '{OP_SCAN_CLR,  C_NEXT,       L_WAIT};
            5'd19:   word = '{OP_SCAN_STEP, C_SCAN_MORE,  L_RS_NLOOP};
            5'd20:   word = '{OP_RS_CALC,   C_NEXT,       L_WAIT};
            5'd21:   word = '{OP_RS_CHECK,  C_ALWAYS,     L_EMIT};
            5'd22:   word = '{OP_SET_NF,    C_ALWAYS,     L_EMIT};
            5'd23:   word = '{OP_EMIT,      C_ALWAYS,     L_WAIT};
            default: word = '{OP_NOP,       C_ALWAYS,     L_WAIT};
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/pfa_sequencer.sv
// ----------------------------------------------------------------------------
// pfa_sequencer
// Step counter with conditional jumps that walks the control store.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_sequencer
    import pfa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  flags_t          flags,
    output logic [OP_W-1:0] op,
    output logic            busy
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;
    logic            jump;

    pfa_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    // Select the jump condition named by the current control word.
    always_comb
    begin
        case (word.cond)
            C_NEXT:       jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NO_START:   jump = !start;
            C_IS_DELETE:  jump = flags.is_delete;
            C_IS_RESIZE:  jump = flags.is_resize;
            C_NOT_CREATE: jump = !flags.is_create;
            C_CR_ERR:     jump = flags.cr_err;
            C_SCAN_MORE:  jump = flags.scan_more;
            C_FIRST_HIT:  jump = flags.first_hit;
            C_CAND_SOME:  jump = flags.cand_some;
            C_CAND_NONE:  jump = !flags.cand_some;
            C_TAG_MISS:   jump = flags.tag_miss;
            default:      jump = 1'b0;
        endcase
        pc_next = jump ? word.target : pc_reg + 1'b1;
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign op   = word.op;
    assign busy = (pc_reg != PC_IDLE);

endmodule

`default_nettype wire

>>> hdl/pfa_datapath.sv
// ----------------------------------------------------------------------------
// pfa_datapath
// Slot table, scan registers, gap arithmetic and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_datapath
    import pfa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [OP_W-1:0] op,
    input  logic [1:0]      action,
    input  logic [15:0]     name_tag,
    input  logic [1:0]      region_type,
    input  logic [31:0]     amount,
    input  logic [31:0]     disk_size,
    input  logic [1:0]      fit_mode,
    input  logic [15:0]     header_size,
    output flags_t          flags,
    output res_t            res,
    output logic            done
);

    // Slot table.
    logic                 slot_valid_reg [SLOT_COUNT];
    logic [31:0]          slot_start_reg [SLOT_COUNT];
    logic [31:0]          slot_length_reg [SLOT_COUNT];
    logic [1:0]           slot_kind_reg [SLOT_COUNT];
    logic [TAG_W-1:0]     slot_tag_reg [SLOT_COUNT];

    // Request registers.
    logic [1:0]           act_reg, act_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [1:0]           kind_reg, kind_next;
    logic [31:0]          amt_reg, amt_next;

    // Scan state.
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic                 cand_valid_reg, cand_valid_next;
    logic [SLOT_BITS-1:0] cand_idx_reg, cand_idx_next;
    logic [31:0]          cand_start_reg, cand_start_next;
    logic [31:0]          cand_len_reg, cand_len_next;
    logic [TAG_W-1:0]     cand_tag_reg, cand_tag_next;
    logic                 prev_valid_reg, prev_valid_next;
    logic [SLOT_BITS-1:0] prev_idx_reg, prev_idx_next;
    logic [31:0]          prev_start_reg, prev_start_next;
    logic [31:0]          prev_len_reg, prev_len_next;

    // Gap walk and resize state.
    logic [32:0]          cursor_reg, cursor_next;
    logic                 found_reg, found_next;
    logic [31:0]          best_start_reg, best_start_next;
    logic [31:0]          best_len_reg, best_len_next;
    logic [SLOT_BITS-1:0] free_idx_reg, free_idx_next;
    logic [33:0]          news_reg, news_next;
    logic [31:0]          bound_reg, bound_next;

    // Result registers.
    res_t                 res_reg, res_next;
    logic                 done_reg, done_next;

    // Combinational terms.
    logic                 rd_valid;
    logic [31:0]          rd_start;
    logic [31:0]          rd_len;
    logic [TAG_W-1:0]     rd_tag;
    logic                 after_prev;
    logic                 beats_cand;
    logic                 scan_take;
    logic                 del_take;
    logic                 ext_any;
    logic                 free_any;
    logic [SLOT_BITS-1:0] free_idx;
    logic [2:0]           cr_code;
    logic [31:0]          gap_bound;
    logic [33:0]          gap_sum;
    logic                 gap_fit;
    logic [31:0]          gap_len;
    logic                 gap_take;
    logic                 mode_best;
    logic                 mode_worst;
    logic [32:0]          end_sum;
    logic [33:0]          news_calc;
    logic [32:0]          rs_end;
    logic                 rs_ok;
    logic                 commit_wr;
    logic                 resize_wr;
    logic                 delete_wr;

    // Single read port of the table at the scan index.
    assign rd_valid = slot_valid_reg[idx_reg];
    assign rd_start = slot_start_reg[idx_reg];
    assign rd_len   = slot_length_reg[idx_reg];
    assign rd_tag   = slot_tag_reg[idx_reg];

    // Next slot in (start, index) order after the previous one; scanning in
    // index order keeps the lowest index among equal starts.
    assign after_prev = !prev_valid_reg || (rd_start > prev_start_reg)
                        || ((rd_start == prev_start_reg) && (idx_reg > prev_idx_reg));
    assign beats_cand = !cand_valid_reg || (rd_start < cand_start_reg);
    assign scan_take  = rd_valid && after_prev && beats_cand;
    assign del_take   = rd_valid && (rd_tag == tag_reg);

    // Occupancy summary from the valid bits and kinds.
    always_comb
    begin
        ext_any  = 1'b0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_BITS'(i);
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (slot_valid_reg[i] && (slot_kind_reg[i] == KIND_EXTENDED))
            begin
                ext_any = 1'b1;
            end
        end
    end

    // Create pre-checks in priority order.
    always_comb
    begin
        if ((kind_reg == KIND_EXTENDED) && ext_any)
        begin
            cr_code = ST_EXT_EXISTS;
        end
        else if (!free_any)
        begin
            cr_code = ST_FULL;
        end
        else if ((amt_reg == 32'd0) || amt_reg[31])
        begin
            cr_code = ST_NO_SPACE;
        end
        else
        begin
            cr_code = ST_OK;
        end
    end

    // Gap test against the next region, or the disk end for the last gap.
    assign gap_bound  = cand_valid_reg ? cand_start_reg : disk_size;
    assign gap_sum    = 34'(cursor_reg) + 34'(amt_reg);
    assign gap_fit    = (gap_sum <= 34'(gap_bound));
    assign gap_len    = gap_bound - cursor_reg[31:0];
    assign mode_best  = (fit_mode == FIT_BEST);
    assign mode_worst = (fit_mode == FIT_WORST);
    always_comb
    begin
        if (mode_best)
        begin
            gap_take = !found_reg || (gap_len < best_len_reg);
        end
        else if (mode_worst)
        begin
            gap_take = !found_reg || (gap_len > best_len_reg);
        end
        else
        begin
            gap_take = !found_reg;
        end
    end
    assign end_sum = 33'(cand_start_reg) + 33'(cand_len_reg);

    // Resize arithmetic: new size is signed, 34 bits covers every case.
    assign news_calc = 34'(prev_len_reg) + {{2{amt_reg[31]}}, amt_reg};
    assign rs_end    = 33'(prev_start_reg) + 33'(news_reg[31:0]);
    assign rs_ok     = !news_reg[33] && !news_reg[32] && (news_reg[31:0] >= 32'd2)
                       && (rs_end <= 33'(bound_reg));

    assign commit_wr = (op == OP_CR_COMMIT) && found_reg;
    assign resize_wr = (op == OP_RS_CHECK) && rs_ok;
    assign delete_wr = (op == OP_DEL_FIN) && cand_valid_reg;

    // Register update per operation.
    always_comb
    begin
        act_next        = act_reg;
        tag_next        = tag_reg;
        kind_next       = kind_reg;
        amt_next        = amt_reg;
        idx_next        = idx_reg;
        cand_valid_next = cand_valid_reg;
        cand_idx_next   = cand_idx_reg;
        cand_start_next = cand_start_reg;
        cand_len_next   = cand_len_reg;
        cand_tag_next   = cand_tag_reg;
        prev_valid_next = prev_valid_reg;
        prev_idx_next   = prev_idx_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        cursor_next     = cursor_reg;
        found_next      = found_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        free_idx_next   = free_idx_reg;
        news_next       = news_reg;
        bound_next      = bound_reg;
        res_next        = res_reg;
        done_next       = 1'b0;
        case (op)
            OP_LOAD:
            begin
                act_next  = action;
                tag_next  = name_tag[TAG_W-1:0];
                kind_next = region_type;
                amt_next  = amount;
                res_next  = '0;
            end
            OP_CR_INIT:
            begin
                res_next.status = cr_code;
                cursor_next     = 33'(header_size);
                found_next      = 1'b0;
                prev_valid_next = 1'b0;
                free_idx_next   = free_idx;
            end
            OP_SCAN_CLR:
            begin
                idx_next        = '0;
                cand_valid_next = 1'b0;
            end
            OP_SCAN_STEP:
            begin
                idx_next = idx_reg + 1'b1;
                if (scan_take)
                begin
                    cand_valid_next = 1'b1;
                    cand_idx_next   = idx_reg;
                    cand_start_next = rd_start;
                    cand_len_next   = rd_len;
                    cand_tag_next   = rd_tag;
                end
            end
            OP_GAP_FIT:
            begin
                if (gap_fit && gap_take)
                begin
                    found_next      = 1'b1;
                    best_start_next = cursor_reg[31:0];
                    best_len_next   = gap_len;
                end
            end
            OP_ADVANCE:
            begin
                prev_valid_next = 1'b1;
                prev_idx_next   = cand_idx_reg;
                prev_start_next = cand_start_reg;
                prev_len_next   = cand_len_reg;
                if (cand_valid_reg && (end_sum > cursor_reg))
                begin
                    cursor_next = end_sum;
                end
            end
            OP_CR_COMMIT:
            begin
                if (found_reg)
                begin
                    res_next.status = ST_OK;
                    res_next.slot   = free_idx_reg;
                    res_next.start  = best_start_reg;
                    res_next.size   = amt_reg;
                end
                else
                begin
                    res_next.status = ST_NO_SPACE;
                end
            end
            OP_DEL_STEP:
            begin
                idx_next = idx_reg + 1'b1;
                if (del_take)
                begin
                    cand_valid_next = 1'b1;
                    cand_idx_next   = idx_reg;
                    cand_start_next = rd_start;
                    cand_len_next   = rd_len;
                end
            end
            OP_DEL_FIN:
            begin
                if (cand_valid_reg)
                begin
                    res_next.status = ST_OK;
                    res_next.slot   = cand_idx_reg;
                    res_next.start  = cand_start_reg;
                    res_next.size   = cand_len_reg;
                end
                else
                begin
                    res_next.status = ST_NOT_FOUND;
                end
            end
            OP_RS_INIT:
            begin
                prev_valid_next = 1'b0;
            end
            OP_RS_CALC:
            begin
                news_next  = news_calc;
                bound_next = gap_bound;
            end
            OP_RS_CHECK:
            begin
                if (rs_ok)
                begin
                    res_next.status = ST_OK;
                    res_next.slot   = prev_idx_reg;
                    res_next.start  = prev_start_reg;
                    res_next.size   = news_reg[31:0];
                end
                else
                begin
                    res_next.status = ST_RANGE;
                end
            end
            OP_SET_NF:
            begin
                res_next.status = ST_NOT_FOUND;
            end
            OP_EMIT:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            done_reg <= done_next;
            if (commit_wr)
            begin
                slot_valid_reg[free_idx_reg] <= 1'b1;
            end
            if (delete_wr)
            begin
                slot_valid_reg[cand_idx_reg] <= 1'b0;
            end
        end
    end

    // Payload registers and table contents.
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        tag_reg        <= tag_next;
        kind_reg       <= kind_next;
        amt_reg        <= amt_next;
        idx_reg        <= idx_next;
        cand_valid_reg <= cand_valid_next;
        cand_idx_reg   <= cand_idx_next;
        cand_start_reg <= cand_start_next;
        cand_len_reg   <= cand_len_next;
        cand_tag_reg   <= cand_tag_next;
        prev_valid_reg <= prev_valid_next;
        prev_idx_reg   <= prev_idx_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        cursor_reg     <= cursor_next;
        found_reg      <= found_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        free_idx_reg   <= free_idx_next;
        news_reg       <= news_next;
        bound_reg      <= bound_next;
        res_reg        <= res_next;
        if (commit_wr)
        begin
            slot_start_reg[free_idx_reg]  <= best_start_reg;
            slot_length_reg[free_idx_reg] <= amt_reg;
            slot_kind_reg[free_idx_reg]   <= kind_reg;
            slot_tag_reg[free_idx_reg]    <= tag_reg;
        end
        if (resize_wr)
        begin
            slot_length_reg[prev_idx_reg] <= news_reg[31:0];
        end
    end

    // Conditions for the sequencer.
    assign flags.is_create = (act_reg == ACT_CREATE);
    assign flags.is_delete = (act_reg == ACT_DELETE);
    assign flags.is_resize = (act_reg == ACT_RESIZE);
    assign flags.cr_err    = (cr_code != ST_OK);
    assign flags.scan_more = (idx_reg != SLOT_LAST);
    assign flags.first_hit = gap_fit && !mode_best && !mode_worst;
    assign flags.cand_some = cand_valid_reg;
    assign flags.tag_miss  = (cand_tag_reg != tag_reg);

    assign res  = res_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

>>> hdl/partition_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator_top
// Four-slot contiguous region allocator with first, best and worst fit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on status, slot, region_start and region_size for exactly one
// cycle while done is high, and cannot be held off, so the receiver must
// take it then. A create that walks the gaps needs a free slot, so at most
// three regions are occupied while it does. In a resize, each step through
// the regions in start order rescans the table one slot per cycle through
// the datapath's single table read port.
// Errors return their status with slot, start and size at zero. Write the
// configuration registers only while busy is low and no result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_fit_allocator_top
    import pfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [15:0] name_tag,
    input  logic [1:0]  region_type,
    input  logic [31:0] amount,
    output logic        done,
    output logic [2:0]  status,
    output logic [1:0]  slot,
    output logic [31:0] region_start,
    output logic [31:0] region_size,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0]     disk_size_reg;
    logic [1:0]      fit_mode_reg;
    logic [15:0]     header_size_reg;
    logic [OP_W-1:0] op;
    flags_t          flags;
    res_t            res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_size_reg   <= 32'd0;
            fit_mode_reg    <= 2'd0;
            header_size_reg <= HEADER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISK_SIZE:   disk_size_reg   <= cfg_data;
                CFG_FIT_MODE:    fit_mode_reg    <= cfg_data[1:0];
                CFG_HEADER_SIZE: header_size_reg <= cfg_data[15:0];
                default:         disk_size_reg   <= disk_size_reg;
            endcase
        end
    end

    pfa_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .op    (op),
        .busy  (busy)
    );

    pfa_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .action      (action),
        .name_tag    (name_tag),
        .region_type (region_type),
        .amount      (amount),
        .disk_size   (disk_size_reg),
        .fit_mode    (fit_mode_reg),
        .header_size (header_size_reg),
        .flags       (flags),
        .res         (res),
        .done        (done)
    );

    // Result beat.
    assign status       = res.status;
    assign slot         = 2'(res.slot);
    assign region_start = res.start;
    assign region_size  = res.size;

endmodule

`default_nettype wire

>>> hdl/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks on the region allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pfa_checker
    import pfa_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [2:0]  status,
    input wire logic [1:0]  slot,
    input wire logic [31:0] region_start,
    input wire logic [31:0] region_size
);

    // An accepted request keeps the block busy until its result is out.
    `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request did not raise busy")

    // The result beat arrives as the block returns to idle.
    `CHK_IMPLY(a_done_idle, clk, rst_n, done, !busy, "result beat while still busy")

    // A result beat lasts one cycle only.
    `CHK_NEXT(a_done_pulse, clk, rst_n, done, !done, "result beat held for two cycles")

    // Failed requests report nothing but their status.
    `CHK_IMPLY(a_err_zero, clk, rst_n, done && (status != ST_OK), (slot == 2'd0) && (region_start == 32'd0) && (region_size == 32'd0), "error result with nonzero fields")

    // A successful request always concerns a region of some size.
    `CHK_IMPLY(a_ok_size, clk, rst_n, done && (status == ST_OK), region_size != 32'd0, "successful result with zero size")

endmodule

bind partition_fit_allocator_top pfa_checker u_pfa_checker (.*);

`default_nettype wire
